// ===== rtl/key_value_table_defines.svh =====
// assertion macros used by the checker file of the key/value table
// no dependencies; expects clk and arst_n in the scope of each use
`ifndef KEY_VALUE_TABLE_DEFINES_SVH
`define KEY_VALUE_TABLE_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define KVT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define KVT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/kvt_pkg.sv =====
// shared types, codes and helpers of the key/value table
// no dependencies
`timescale 1ns / 1ps

package kvt_pkg;

	localparam int ENTRIES_DEF     = 16;
	localparam int KEY_BYTES_DEF   = 8;
	localparam int VALUE_BYTES_DEF = 8;
	localparam int ENTRIES_MAX     = 1024;

	localparam int WORD_W    = 64;
	localparam int LEN_W     = 4;
	localparam int IDX_MAX_W = $clog2(ENTRIES_MAX);

	localparam logic [1:0] OP_GET = 2'd0;
	localparam logic [1:0] OP_PUT = 2'd1;
	localparam logic [1:0] OP_DEL = 2'd2;

	localparam logic [1:0] STAT_OK         = 2'd0;
	localparam logic [1:0] STAT_NOT_FOUND  = 2'd1;
	localparam logic [1:0] STAT_WRONG_SIZE = 2'd2;
	localparam logic [1:0] STAT_FULL       = 2'd3;

	typedef enum logic [1:0] {
		S_IDLE,
		S_LAUNCH,
		S_SCAN
	} state_t;

	// search token handed from cell to cell
	typedef struct packed {
		logic                 valid;
		logic                 found;
		logic [IDX_MAX_W-1:0] match_idx;
		logic [WORD_W-1:0]    match_val;
		logic [LEN_W-1:0]     match_len;
		logic                 free_found;
		logic [IDX_MAX_W-1:0] free_idx;
	} tok_t;

	// write-back command broadcast to all cells
	typedef struct packed {
		logic                 en;
		logic [IDX_MAX_W-1:0] idx;
		logic                 set_valid;
		logic                 clr_valid;
		logic                 load_key;
		logic                 load_data;
		logic [WORD_W-1:0]    key;
		logic [WORD_W-1:0]    value;
		logic [LEN_W-1:0]     len;
	} wr_t;

	// keeps the lowest n bytes of a word
	function automatic logic [WORD_W-1:0] byte_mask(input logic [7:0] n);
		logic [WORD_W-1:0] m;
		m = '0;
		for (int b = 0; b < WORD_W / 8; b++) begin
			if (8'(b) < n) begin
				m[b*8 +: 8] = 8'hff;
			end
		end
		return m;
	endfunction

endpackage

// ===== rtl/key_value_table.sv =====
// top level of the key/value table: request capture, cell chain, write-back
// depends on kvt_pkg and kvt_cell
`timescale 1ns / 1ps

// key/value table with ENTRIES slots of one key and one value each
//
// request channel: opcode, lookup_key, key_length, put_value and put_length
//   are taken in a transfer at a rising edge with start high and busy low
// result channel: status, read_value, read_length and used_entries are valid
//   for exactly one cycle while done is high; the receiver cannot stall, so
//   a result that is not taken in that cycle is gone
// operation: the request is registered, then a search token walks the row
//   of cells, one cell per cycle, collecting the lowest matching entry and
//   the lowest free slot; at the end of the row the outcome is decided and,
//   for a put or delete that succeeds, one write-back command updates the chosen cell
// sequence: the transfer moves the state to S_LAUNCH, the token then passes
//   the register of every cell in turn, and done is registered from the token
//   leaving the last cell; a new request is not taken before the result of the
//   last one, and the next start is taken in the cycle where done is high
// reset: all valid marks and the entry count clear at once, busy and done
//   go low; keys and values hold no reset and are never read before written
module key_value_table #(
	parameter int ENTRIES     = kvt_pkg::ENTRIES_DEF,
	parameter int KEY_BYTES   = kvt_pkg::KEY_BYTES_DEF,
	parameter int VALUE_BYTES = kvt_pkg::VALUE_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  opcode,
	input  logic [63:0] lookup_key,
	input  logic [7:0]  key_length,
	input  logic [63:0] put_value,
	input  logic [7:0]  put_length,
	output logic        done,
	output logic [1:0]  status,
	output logic [63:0] read_value,
	output logic [3:0]  read_length,
	output logic [4:0]  used_entries
);

	localparam int KEY_W = 8 * KEY_BYTES;
	localparam int VAL_W = 8 * VALUE_BYTES;
	localparam int CNT_W = $clog2(ENTRIES + 1);

	// state machine
	kvt_pkg::state_t state_q, state_d;

	// registered request
	logic [1:0]                req_op_q;
	logic [KEY_W-1:0]          req_key_q;
	logic                      req_ok_q;
	logic [VAL_W-1:0]          req_val_q;
	logic [kvt_pkg::LEN_W-1:0] req_len_q;
	logic                      req_big_q;

	// request shaping at the input
	logic                      accept;
	logic [63:0]               key_c;
	logic                      key_ok_c;
	logic [63:0]               val_c;
	logic                      big_c;

	// entry count and result registers
	logic [CNT_W-1:0]          count_q, count_d;
	logic                      done_q;
	logic [1:0]                status_q, status_d;
	logic [63:0]               rval_q, rval_d;
	logic [3:0]                rlen_q, rlen_d;
	logic                      finish;

	// cell chain
	kvt_pkg::tok_t             chain [ENTRIES+1];
	kvt_pkg::wr_t              wr;

	assign accept = start && !busy;

	always_comb begin
		big_c = (key_length > 8'(KEY_BYTES)) || (put_length > 8'(VALUE_BYTES));
		val_c = put_value & kvt_pkg::byte_mask(put_length);
		if (opcode == kvt_pkg::OP_PUT) begin
			// put searches and stores the masked key
			key_c    = lookup_key & kvt_pkg::byte_mask(key_length);
			key_ok_c = 1'b1;
		end else begin
			// get and delete compare the whole word; bytes beyond the stored
			// key width must be zero to match
			key_c    = lookup_key;
			key_ok_c = (lookup_key & ~kvt_pkg::byte_mask(8'(KEY_BYTES))) == 64'd0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_op_q  <= opcode;
			req_key_q <= key_c[KEY_W-1:0];
			req_ok_q  <= key_ok_c;
			req_val_q <= val_c[VAL_W-1:0];
			req_len_q <= put_length[kvt_pkg::LEN_W-1:0];
			req_big_q <= big_c;
		end
	end

	// token launched into the first cell
	always_comb begin
		chain[0]       = '0;
		chain[0].valid = (state_q == kvt_pkg::S_LAUNCH);
	end

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		kvt_cell #(
			.CELL_ID (i),
			.KEY_W   (KEY_W),
			.VAL_W   (VAL_W)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.tok_in     (chain[i]),
			.tok_out    (chain[i+1]),
			.req_key    (req_key_q),
			.req_key_ok (req_ok_q),
			.wr         (wr)
		);
	end

	// token leaving the last cell ends the search
	assign finish = (state_q == kvt_pkg::S_SCAN) && chain[ENTRIES].valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kvt_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state, decision and write-back
	always_comb begin
		state_d  = state_q;
		count_d  = count_q;
		status_d = kvt_pkg::STAT_NOT_FOUND;
		rval_d   = 64'd0;
		rlen_d   = 4'd0;
		wr       = '0;
		wr.key   = kvt_pkg::WORD_W'(req_key_q);
		wr.value = kvt_pkg::WORD_W'(req_val_q);
		wr.len   = req_len_q;

		case (state_q)
			kvt_pkg::S_IDLE: begin
				if (accept) begin
					state_d = kvt_pkg::S_LAUNCH;
				end
			end
			kvt_pkg::S_LAUNCH: begin
				state_d = kvt_pkg::S_SCAN;
			end
			kvt_pkg::S_SCAN: begin
				if (finish) begin
					state_d = kvt_pkg::S_IDLE;
					case (req_op_q)
						kvt_pkg::OP_GET: begin
							if (chain[ENTRIES].found) begin
								status_d = kvt_pkg::STAT_OK;
								rval_d   = chain[ENTRIES].match_val;
								rlen_d   = chain[ENTRIES].match_len;
							end
						end
						kvt_pkg::OP_PUT: begin
							if (req_big_q) begin
								status_d = kvt_pkg::STAT_WRONG_SIZE;
							end else if (chain[ENTRIES].found) begin
								// update in place, also when the table is full
								status_d     = kvt_pkg::STAT_OK;
								wr.en        = 1'b1;
								wr.idx       = chain[ENTRIES].match_idx;
								wr.load_data = 1'b1;
							end else if (count_q >= CNT_W'(ENTRIES)) begin
								status_d = kvt_pkg::STAT_FULL;
							end else if (chain[ENTRIES].free_found) begin
								status_d     = kvt_pkg::STAT_OK;
								wr.en        = 1'b1;
								wr.idx       = chain[ENTRIES].free_idx;
								wr.set_valid = 1'b1;
								wr.load_key  = 1'b1;
								wr.load_data = 1'b1;
								count_d      = count_q + CNT_W'(1);
							end else begin
								status_d = kvt_pkg::STAT_FULL;
							end
						end
						kvt_pkg::OP_DEL: begin
							if (chain[ENTRIES].found) begin
								status_d     = kvt_pkg::STAT_OK;
								wr.en        = 1'b1;
								wr.idx       = chain[ENTRIES].match_idx;
								wr.clr_valid = 1'b1;
								if (count_q != '0) begin
									count_d = count_q - CNT_W'(1);
								end
							end
						end
						default: begin
							status_d = kvt_pkg::STAT_NOT_FOUND;
						end
					endcase
				end
			end
			default: begin
				state_d = kvt_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			count_q <= count_d;
			done_q  <= finish;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			status_q <= status_d;
			rval_q   <= rval_d;
			rlen_q   <= rlen_d;
		end
	end

	assign busy         = (state_q != kvt_pkg::S_IDLE);
	assign done         = done_q;
	assign status       = status_q;
	assign read_value   = rval_q;
	assign read_length  = rlen_q;
	assign used_entries = 5'(count_q);

endmodule

// ===== rtl/kvt_cell.sv =====
// one entry of the key/value table and its stage of the search chain
// depends on kvt_pkg
`timescale 1ns / 1ps

module kvt_cell #(
	parameter int CELL_ID = 0,
	parameter int KEY_W   = 64,
	parameter int VAL_W   = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  kvt_pkg::tok_t      tok_in,
	output kvt_pkg::tok_t      tok_out,
	input  logic [KEY_W-1:0]   req_key,
	input  logic               req_key_ok,
	input  kvt_pkg::wr_t       wr
);

	logic                      valid_q;
	logic [KEY_W-1:0]          key_q;
	logic [VAL_W-1:0]          val_q;
	logic [kvt_pkg::LEN_W-1:0] len_q;
	logic                      tok_vld_q;
	kvt_pkg::tok_t             tok_dat_q;
	kvt_pkg::tok_t             tok_nxt;
	logic                      hit;
	logic                      wr_sel;

	assign hit    = valid_q && req_key_ok && (key_q == req_key);
	assign wr_sel = wr.en && (wr.idx == kvt_pkg::IDX_MAX_W'(CELL_ID));

	always_comb begin
		tok_nxt = tok_in;
		// lowest match and lowest free slot win
		if (!tok_in.found && hit) begin
			tok_nxt.found     = 1'b1;
			tok_nxt.match_idx = kvt_pkg::IDX_MAX_W'(CELL_ID);
			tok_nxt.match_val = kvt_pkg::WORD_W'(val_q);
			tok_nxt.match_len = len_q;
		end
		if (!tok_in.free_found && !valid_q) begin
			tok_nxt.free_found = 1'b1;
			tok_nxt.free_idx   = kvt_pkg::IDX_MAX_W'(CELL_ID);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= 1'b0;
			tok_vld_q <= 1'b0;
		end else begin
			tok_vld_q <= tok_in.valid;
			if (wr_sel && wr.set_valid) begin
				valid_q <= 1'b1;
			end else if (wr_sel && wr.clr_valid) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		tok_dat_q <= tok_nxt;
		if (wr_sel && wr.load_key) begin
			key_q <= wr.key[KEY_W-1:0];
		end
		if (wr_sel && wr.load_data) begin
			val_q <= wr.value[VAL_W-1:0];
			len_q <= wr.len;
		end
	end

	always_comb begin
		tok_out       = tok_dat_q;
		tok_out.valid = tok_vld_q;
	end

endmodule

// ===== rtl/kvt_checker.sv =====
// port-level checks of the key/value table, bound to the top level
// depends on kvt_pkg and key_value_table_defines.svh
`timescale 1ns / 1ps
`include "key_value_table_defines.svh"

module kvt_checker #(
	parameter int VALUE_BYTES = kvt_pkg::VALUE_BYTES_DEF
) (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [1:0]  status,
	input logic [63:0] read_value,
	input logic [3:0]  read_length
);

	// a taken request keeps the block busy until its result
	`KVT_ASSERT_NEXT(a_busy_after_start, start && !busy, busy, "busy low after request transfer")

	// a result only closes a request in progress
	`KVT_ASSERT_NOW(a_done_after_busy, done, !busy && $past(busy), "result without request")

	// only a successful get carries data
	`KVT_ASSERT_NOW(a_data_on_ok_only, done && (status != kvt_pkg::STAT_OK),
		(read_value == 64'd0) && (read_length == 4'd0), "data on failed request")

	// stored length never exceeds the value width
	`KVT_ASSERT_NOW(a_len_bound, done, read_length <= 4'(VALUE_BYTES), "read length too large")

endmodule

bind key_value_table kvt_checker #(.VALUE_BYTES(VALUE_BYTES)) u_kvt_checker (.*);

// ===== bench/key_value_table_test.sv =====
// self-checking bench for key_value_table: directed then random get/put/delete requests
// depends on kvt_pkg and the key_value_table rtl; a scoreboard class mirrors the table contents
`timescale 1ns / 1ps

module key_value_table_test;

	localparam int N_SLOTS      = kvt_pkg::ENTRIES_DEF;
	localparam int KEY_LIMIT    = kvt_pkg::KEY_BYTES_DEF;
	localparam int VALUE_LIMIT  = kvt_pkg::VALUE_BYTES_DEF;
	localparam int POOL_SIZE    = 24;
	localparam int RANDOM_ITEMS = 900;
	localparam int DRAIN_CYCLES = N_SLOTS + 6;
	localparam int CYCLE_LIMIT  = 400000;

	// opcode with no operation behind it
	localparam logic [1:0] OP_UNUSED = 2'd3;

	// put and delete shares per block of 100 random requests after the 12 junk ones, the rest are gets
	localparam int PUT_MIX [9] = '{60, 30, 15, 65, 35, 10, 55, 30, 20};
	localparam int DEL_MIX [9] = '{ 8, 30, 60,  5, 25, 65, 10, 30, 50};

	typedef struct packed {
		logic [1:0]  status;
		logic [63:0] value;
		logic [3:0]  len;
		logic [4:0]  used;
	} kv_result_t;

	// shadow copy of the table; one expectation per accepted request
	class kv_scoreboard;
		bit              slot_valid [N_SLOTS];
		bit [63:0]       slot_key   [N_SLOTS];
		bit [63:0]       slot_value [N_SLOTS];
		bit [3:0]        slot_len   [N_SLOTS];
		int unsigned     used_count;
		kv_result_t      pending [$];
		int unsigned     mismatches;

		static function bit [63:0] keep_bytes(int unsigned n);
			if (n >= 8) begin
				return '1;
			end
			return (64'd1 << (8 * n)) - 64'd1;
		endfunction

		function int unsigned find_key(bit [63:0] k);
			for (int i = 0; i < N_SLOTS; i++) begin
				if (slot_valid[i] && slot_key[i] == k) begin
					return i;
				end
			end
			return N_SLOTS;
		endfunction

		function int unsigned find_free();
			for (int i = 0; i < N_SLOTS; i++) begin
				if (!slot_valid[i]) begin
					return i;
				end
			end
			return N_SLOTS;
		endfunction

		// works out the table update and the answer for one accepted request
		function void note_request(logic [1:0] op, logic [63:0] key, logic [7:0] klen,
				logic [63:0] val, logic [7:0] vlen);
			kv_result_t  r;
			int unsigned idx;
			bit [63:0]   k;
			bit [63:0]   v;
			r = '{status: kvt_pkg::STAT_NOT_FOUND, value: '0, len: '0, used: '0};
			case (op)
				kvt_pkg::OP_GET: begin
					idx = find_key(key);
					if (idx < N_SLOTS) begin
						r.status = kvt_pkg::STAT_OK;
						r.len    = slot_len[idx];
						r.value  = slot_value[idx] & keep_bytes(slot_len[idx]);
					end
				end
				kvt_pkg::OP_PUT: begin
					if (klen > KEY_LIMIT || vlen > VALUE_LIMIT) begin
						r.status = kvt_pkg::STAT_WRONG_SIZE;
					end else begin
						k   = key & keep_bytes(klen);
						v   = val & keep_bytes(vlen);
						idx = find_key(k);
						if (idx < N_SLOTS) begin
							slot_value[idx] = v;
							slot_len[idx]   = vlen[3:0];
							r.status        = kvt_pkg::STAT_OK;
						end else if (used_count >= N_SLOTS) begin
							r.status = kvt_pkg::STAT_FULL;
						end else begin
							idx = find_free();
							slot_key[idx]   = k;
							slot_value[idx] = v;
							slot_len[idx]   = vlen[3:0];
							slot_valid[idx] = 1'b1;
							used_count++;
							r.status = kvt_pkg::STAT_OK;
						end
					end
				end
				kvt_pkg::OP_DEL: begin
					idx = find_key(key);
					if (idx < N_SLOTS) begin
						slot_valid[idx] = 1'b0;
						if (used_count > 0) begin
							used_count--;
						end
						r.status = kvt_pkg::STAT_OK;
					end
				end
				default: begin
				end
			endcase
			r.used = used_count[4:0];
			pending.push_back(r);
		endfunction

		function void check_result(logic [1:0] st, logic [63:0] val, logic [3:0] len,
				logic [4:0] used);
			kv_result_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual status %0d used %0d",
					$time, st, used);
				mismatches++;
				return;
			end
			want = pending.pop_front();
			if (st !== want.status) begin
				$display("%0t: status expected %0d, actual %0d", $time, want.status, st);
				mismatches++;
			end
			if (val !== want.value) begin
				$display("%0t: read_value expected %h, actual %h", $time, want.value, val);
				mismatches++;
			end
			if (len !== want.len) begin
				$display("%0t: read_length expected %0d, actual %0d", $time, want.len, len);
				mismatches++;
			end
			if (used !== want.used) begin
				$display("%0t: used_entries expected %0d, actual %0d", $time, want.used, used);
				mismatches++;
			end
		endfunction
	endclass

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        start        = 1'b0;
	logic        busy;
	logic [1:0]  opcode       = kvt_pkg::OP_GET;
	logic [63:0] lookup_key   = '0;
	logic [7:0]  key_length   = '0;
	logic [63:0] put_value    = '0;
	logic [7:0]  put_length   = '0;
	logic        done;
	logic [1:0]  status;
	logic [63:0] read_value;
	logic [3:0]  read_length;
	logic [4:0]  used_entries;

	kv_scoreboard sb = new;
	int unsigned  cycle_count = 0;
	logic [63:0]  key_pool  [POOL_SIZE];
	int unsigned  pool_span [POOL_SIZE];
	bit           quiet_run = 1'b0;

	key_value_table #(
		.ENTRIES    (N_SLOTS),
		.KEY_BYTES  (KEY_LIMIT),
		.VALUE_BYTES(VALUE_LIMIT)
	) uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.opcode      (opcode),
		.lookup_key  (lookup_key),
		.key_length  (key_length),
		.put_value   (put_value),
		.put_length  (put_length),
		.done        (done),
		.status      (status),
		.read_value  (read_value),
		.read_length (read_length),
		.used_entries(used_entries)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 0;
	end

	// watchdog against a hung request channel
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// done is sampled before this edge updates it, so each strobe is seen once
	always @(posedge clk) begin
		if (done) begin
			sb.check_result(status, read_value, read_length, used_entries);
		end
	end

	// called just after a rising edge; holds start until the transfer happens
	task automatic drive_request(input logic [1:0] op, input logic [63:0] key,
			input logic [7:0] klen, input logic [63:0] val, input logic [7:0] vlen);
		opcode     <= op;
		lookup_key <= key;
		key_length <= klen;
		put_value  <= val;
		put_length <= vlen;
		start      <= 1'b1;
		@(posedge clk);
		while (busy) begin
			@(posedge clk);
		end
		sb.note_request(op, key, klen, val, vlen);
	endtask

	// start low with junk on the fields, long enough to land on any scan phase
	task automatic idle_gap(input int unsigned n);
		start      <= 1'b0;
		opcode     <= 2'($urandom);
		lookup_key <= {$urandom, $urandom};
		key_length <= 8'($urandom);
		put_value  <= {$urandom, $urandom};
		put_length <= 8'($urandom);
		repeat (n) @(posedge clk);
	endtask

	task automatic maybe_idle();
		if (!quiet_run && $urandom_range(0, 99) < 6) begin
			idle_gap($urandom_range(1, 2 * N_SLOTS + 4));
		end
	endtask

	// mostly requests on a small key pool so the table fills and drains; some junk
	task automatic random_request(input int unsigned put_pct, input int unsigned del_pct);
		int unsigned roll;
		int unsigned pick;
		logic [1:0]  op;
		logic [63:0] key;
		logic [63:0] val;
		int unsigned klen;
		int unsigned vlen;
		roll = $urandom_range(0, 99);
		pick = $urandom_range(0, POOL_SIZE - 1);
		key  = key_pool[pick];
		klen = $urandom_range(pool_span[pick], KEY_LIMIT);
		val  = {$urandom, $urandom};
		vlen = $urandom_range(0, VALUE_LIMIT);
		if (roll < 12) begin
			op   = 2'($urandom_range(0, 3));
			key  = {$urandom, $urandom};
			klen = $urandom_range(0, 255);
			vlen = $urandom_range(0, 255);
		end else if (roll < 12 + put_pct) begin
			op = kvt_pkg::OP_PUT;
		end else if (roll < 12 + put_pct + del_pct) begin
			op = kvt_pkg::OP_DEL;
		end else begin
			op = kvt_pkg::OP_GET;
		end
		drive_request(op, key, 8'(klen), val, 8'(vlen));
	endtask

	initial begin
		// pool keys carry zeros above their span, so a put with a longer
		// key length still lands on the same stored key
		for (int i = 0; i < POOL_SIZE; i++) begin
			pool_span[i] = $urandom_range(0, KEY_LIMIT);
			key_pool[i]  = {$urandom, $urandom} & kv_scoreboard::keep_bytes(pool_span[i]);
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table, unused opcode, size limits
		drive_request(kvt_pkg::OP_GET, 64'h0, 8'd8, 64'h0, 8'd0);
		drive_request(kvt_pkg::OP_DEL, 64'h0, 8'd8, 64'h0, 8'd0);
		drive_request(OP_UNUSED, '1, 8'd8, '1, 8'd8);
		drive_request(kvt_pkg::OP_PUT, 64'h1, 8'd9, 64'h1, 8'd0);
		drive_request(kvt_pkg::OP_PUT, 64'h1, 8'd8, 64'h1, 8'd9);
		drive_request(kvt_pkg::OP_PUT, '1, 8'd255, '1, 8'd255);
		// full-width key and value
		drive_request(kvt_pkg::OP_PUT, '1, 8'd8, '1, 8'd8);
		drive_request(kvt_pkg::OP_GET, '1, 8'd0, 64'h0, 8'd0);
		// short key is masked before store, get compares the word as given
		drive_request(kvt_pkg::OP_PUT, 64'h1122_3344_5566_7788, 8'd3, '1, 8'd3);
		drive_request(kvt_pkg::OP_GET, 64'h1122_3344_5566_7788, 8'd8, 64'h0, 8'd0);
		drive_request(kvt_pkg::OP_GET, 64'h0000_0000_0066_7788, 8'd8, 64'h0, 8'd0);
		// zero-length key and value
		drive_request(kvt_pkg::OP_PUT, 64'hdead_beef_cafe_f00d, 8'd0, '1, 8'd0);
		drive_request(kvt_pkg::OP_GET, 64'h0, 8'd0, 64'h0, 8'd0);
		// update in place with a shorter value
		drive_request(kvt_pkg::OP_PUT, '1, 8'd8, 64'h0123_4567_89ab_cdef, 8'd5);
		drive_request(kvt_pkg::OP_GET, '1, 8'd8, 64'h0, 8'd0);
		// delete frees the middle slot, the next new key refills it
		drive_request(kvt_pkg::OP_DEL, 64'h0000_0000_0066_7788, 8'd8, 64'h0, 8'd0);
		drive_request(kvt_pkg::OP_GET, 64'h0000_0000_0066_7788, 8'd8, 64'h0, 8'd0);
		drive_request(kvt_pkg::OP_DEL, 64'h0000_0000_0066_7788, 8'd8, 64'h0, 8'd0);
		drive_request(kvt_pkg::OP_PUT, 64'hffff_ffff_ffff_ffa5, 8'd1, 64'h55aa, 8'd2);
		drive_request(kvt_pkg::OP_GET, 64'h0000_0000_0000_00a5, 8'd1, 64'h0, 8'd0);
		drive_request(OP_UNUSED, 64'h0, 8'd0, 64'h0, 8'd0);
		drive_request(kvt_pkg::OP_DEL, '1, 8'd8, 64'h0, 8'd0);
		drive_request(kvt_pkg::OP_DEL, 64'h0, 8'd8, 64'h0, 8'd0);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			// back-to-back stretch with no idling at all
			quiet_run = (n >= 300 && n < 500);
			maybe_idle();
			random_request(PUT_MIX[(n / 100) % 9], DEL_MIX[(n / 100) % 9]);
		end
		idle_gap(1);

		while (sb.pending.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
